// ===== rtl/cutoff_neighbor_bin_max_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cutoff neighbor bin maximum counter
// Shared property forms used by the checker of the block.
// ----------------------------------------------------------------------------
`ifndef CUTOFF_NEIGHBOR_BIN_MAX_COUNTER_ASSERT_SVH
`define CUTOFF_NEIGHBOR_BIN_MAX_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNBM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CNBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cnbm_pkg.sv =====
// ----------------------------------------------------------------------------
// cnbm_pkg
// Types, constants and helpers shared by the neighbor bin counter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cnbm_pkg;

   localparam int COORD_BITS    = 24;
   localparam int SQ_BITS       = 2 * COORD_BITS;
   localparam int SUM_BITS      = SQ_BITS + 2;
   localparam int CUT_BITS      = 52;
   localparam int SPC_BITS      = 3;
   localparam int NSP_BITS      = 4;
   localparam int MAP_BITS      = 32;
   localparam int BIN_BITS      = 2;
   localparam int CNT_BITS      = 12;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;
   localparam int MID_DEPTH     = 4;
   localparam int OUT_DEPTH     = 2;

   localparam logic [CNT_BITS-1:0] COUNT_MAX = 12'd4095;

   // Register indexes (byte address divided by eight).
   localparam logic [1:0] CSR_CUTOFF  = 2'd0;
   localparam logic [1:0] CSR_SPECIES = 2'd1;
   localparam logic [1:0] CSR_MAP     = 2'd2;

   typedef struct packed {
      logic [COORD_BITS-1:0] center_x;
      logic [COORD_BITS-1:0] center_y;
      logic [COORD_BITS-1:0] center_z;
      logic [COORD_BITS-1:0] neighbor_x;
      logic [COORD_BITS-1:0] neighbor_y;
      logic [COORD_BITS-1:0] neighbor_z;
      logic [1:0]            center_species;
      logic [1:0]            neighbor_species;
      logic                  last_neighbor;
      logic                  last_atom;
   } req_type;

   typedef struct packed {
      logic [CNT_BITS-1:0] atom_max_count;
      logic [CNT_BITS-1:0] overall_max_count;
      logic                final_res;
   } rsp_type;

   typedef struct packed {
      logic [CUT_BITS-1:0] cutoff_squared;
      logic [SPC_BITS-1:0] species_count;
      logic [MAP_BITS-1:0] pair_bin_map;
   } cfg_type;

   // One classified pair as handed from the front to the back.
   typedef struct packed {
      logic                inc;
      logic [BIN_BITS-1:0] bin;
      logic                last_neighbor;
      logic                last_atom;
   } mid_type;

   localparam int MID_BITS = $bits(mid_type);
   localparam int RSP_BITS = $bits(rsp_type);

   // Species count in use: zero acts as one, and the count is capped at max_sp.
   function automatic logic [NSP_BITS-1:0] eff_species(logic [SPC_BITS-1:0] sc,
                                                       logic [NSP_BITS-1:0] max_sp);
      logic [NSP_BITS-1:0] n;
      n = {1'b0, sc};
      if (n == '0) begin
         n = NSP_BITS'(1);
      end
      if (n > max_sp) begin
         n = max_sp;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cnbm_queue.sv =====
// ----------------------------------------------------------------------------
// cnbm_queue
// Small first-in first-out queue with the oldest entry shown at its head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnbm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_i,
   input  wire logic [WIDTH-1:0] data_i,
   output logic                  full_o,
   input  wire logic             pop_i,
   output logic [WIDTH-1:0]      data_o,
   output logic                  empty_o
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full_o  = (cnt_ff == CW'(DEPTH));
   assign empty_o = (cnt_ff == '0);
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign data_o  = mem_ff[rd_ptr_ff];

   // Pointers wrap at the depth, which need not be a power of two.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cnbm_front.sv =====
// ----------------------------------------------------------------------------
// cnbm_front
// Three-stage distance pipeline that classifies each pair for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnbm_front #(
   parameter int MAX_SPECIES = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cnbm_pkg::cfg_type cfg_i,
   input  wire logic              push_i,
   input  wire cnbm_pkg::req_type req_i,
   output logic                   full_o,
   output logic                   mid_push_o,
   output cnbm_pkg::mid_type      mid_o,
   input  wire logic              mid_full_i
);

   localparam int CB = cnbm_pkg::COORD_BITS;

   logic                       advance;
   logic                       accept;
   logic [CB-1:0]              mag [3];
   cnbm_pkg::mid_type          side;
   logic [cnbm_pkg::NSP_BITS-1:0] n_sp;
   logic [5:0]                 idx;
   logic [cnbm_pkg::BIN_BITS-1:0] bin;

   logic                       v0_ff, v1_ff, v2_ff;
   logic [CB-1:0]              mag_ff [3];
   logic [cnbm_pkg::SQ_BITS-1:0]  sq_ff [3];
   logic [cnbm_pkg::SUM_BITS-1:0] sum_ff;
   cnbm_pkg::mid_type          s0_ff, s1_ff, s2_ff;

   // The whole pipeline holds when its last stage cannot enter the queue.
   assign advance = !v2_ff || !mid_full_i;
   assign full_o  = !advance;
   assign accept  = push_i && advance;

   // Magnitude of each coordinate difference.
   always_comb begin
      logic [CB-1:0] cpos [3];
      logic [CB-1:0] npos [3];
      logic [CB:0]   diff;
      logic [CB:0]   neg;
      cpos[0] = req_i.center_x;
      cpos[1] = req_i.center_y;
      cpos[2] = req_i.center_z;
      npos[0] = req_i.neighbor_x;
      npos[1] = req_i.neighbor_y;
      npos[2] = req_i.neighbor_z;
      for (int a = 0; a < 3; a++) begin
         diff   = {npos[a][CB-1], npos[a]} - {cpos[a][CB-1], cpos[a]};
         neg    = ~diff + (CB + 1)'(1);
         mag[a] = diff[CB] ? neg[CB-1:0] : diff[CB-1:0];
      end
   end

   // Bin selection from the species pair. The inc field carries whether the
   // bin is one that is kept; the distance test joins it in the last stage.
   always_comb begin
      n_sp = cnbm_pkg::eff_species(cfg_i.species_count,
                                   cnbm_pkg::NSP_BITS'(MAX_SPECIES));
      idx  = 6'(req_i.center_species) * 6'(n_sp) + 6'(req_i.neighbor_species);
      bin  = '0;
      if (n_sp > cnbm_pkg::NSP_BITS'(1) && idx < 6'd16) begin
         bin = cfg_i.pair_bin_map[{idx[3:0], 1'b0} +: cnbm_pkg::BIN_BITS];
      end
      side.inc           = (int'(bin) < MAX_SPECIES);
      side.bin           = bin;
      side.last_neighbor = req_i.last_neighbor;
      side.last_atom     = req_i.last_atom;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= accept;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            mag_ff[a] <= mag[a];
            sq_ff[a]  <= {{CB{1'b0}}, mag_ff[a]} * {{CB{1'b0}}, mag_ff[a]};
         end
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         s0_ff  <= side;
         s1_ff  <= s0_ff;
         s2_ff  <= s1_ff;
      end
   end

   always_comb begin
      mid_o     = s2_ff;
      mid_o.inc = s2_ff.inc && (sum_ff != '0) &&
                  (cnbm_pkg::CUT_BITS'(sum_ff) < cfg_i.cutoff_squared);
   end

   assign mid_push_o = v2_ff && !mid_full_i;

endmodule

`default_nettype wire

// ===== rtl/cnbm_back.sv =====
// ----------------------------------------------------------------------------
// cnbm_back
// Bin counters and running maximum, one classified pair per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cnbm_back #(
   parameter int MAX_SPECIES = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [cnbm_pkg::SPC_BITS-1:0]       species_count_i,
   input  wire cnbm_pkg::mid_type                   mid_i,
   input  wire logic                                mid_empty_i,
   output logic                                     mid_pop_o,
   input  wire logic                                out_full_i,
   output logic                                     out_push_o,
   output cnbm_pkg::rsp_type                        out_o
);

   localparam int CNB = cnbm_pkg::CNT_BITS;

   logic [CNB-1:0] bins_ff [MAX_SPECIES];
   logic [CNB-1:0] bins_in [MAX_SPECIES];
   logic [CNB-1:0] upd [MAX_SPECIES];
   logic [CNB-1:0] rm_ff, rm_in;
   logic [CNB-1:0] amax, rm_new;
   logic [cnbm_pkg::NSP_BITS-1:0] n_sp;
   logic           take;

   // A report waits for room in the result queue; plain pairs never wait.
   assign take       = !mid_empty_i && (!mid_i.last_neighbor || !out_full_i);
   assign mid_pop_o  = take;
   assign out_push_o = take && mid_i.last_neighbor;
   assign n_sp       = cnbm_pkg::eff_species(species_count_i,
                                             cnbm_pkg::NSP_BITS'(MAX_SPECIES));

   always_comb begin
      bins_in = bins_ff;
      rm_in   = rm_ff;
      amax    = '0;
      for (int i = 0; i < MAX_SPECIES; i++) begin
         upd[i] = bins_ff[i];
         if (mid_i.inc && int'(mid_i.bin) == i && bins_ff[i] != cnbm_pkg::COUNT_MAX) begin
            upd[i] = bins_ff[i] + CNB'(1);
         end
      end
      // Bins at or above the species count are counted but not reported.
      for (int i = 0; i < MAX_SPECIES; i++) begin
         if (cnbm_pkg::NSP_BITS'(i) < n_sp && upd[i] > amax) begin
            amax = upd[i];
         end
      end
      rm_new = (amax > rm_ff) ? amax : rm_ff;
      if (take) begin
         if (mid_i.last_neighbor) begin
            for (int i = 0; i < MAX_SPECIES; i++) begin
               bins_in[i] = '0;
            end
            rm_in = mid_i.last_atom ? '0 : rm_new;
         end else begin
            bins_in = upd;
         end
      end
   end

   assign out_o = '{atom_max_count:    amax,
                    overall_max_count: rm_new,
                    final_res:         mid_i.last_atom};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SPECIES; i++) begin
            bins_ff[i] <= '0;
         end
         rm_ff <= '0;
      end else begin
         bins_ff <= bins_in;
         rm_ff   <= rm_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cutoff_neighbor_bin_max_counter.sv =====
// ----------------------------------------------------------------------------
// cutoff_neighbor_bin_max_counter
// Counts neighbors inside a cutoff radius per species-pair bin and reports
// the per-atom and running maximum bin counts.
// ----------------------------------------------------------------------------
// The block takes one center/neighbor pair per clock cycle while full is low.
// A pair passes through the distance pipeline stages (difference, square,
// sum), waits in a four-entry queue, and is counted by the back end in the
// cycle it leaves that queue. Results wait in a two-entry output queue; the
// back end holds only a report while that queue is full, and the front
// stalls (full goes high) only once the middle queue has filled behind it.
// The sustained rate is one pair per cycle while reports can enter the
// output queue, since the back end updates the bin counters as each pair
// leaves the middle queue. Counters come out of reset at zero at once, with
// no clearing sweep.
`timescale 1ns / 1ps
`default_nettype none

module cutoff_neighbor_bin_max_counter #(
   parameter int MAX_SPECIES = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push,
   input  wire cnbm_pkg::req_type                      req_item,
   output logic                                        full,
   output logic                                        empty,
   input  wire logic                                   pop,
   output cnbm_pkg::rsp_type                           rsp_item,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [cnbm_pkg::CSR_ADDR_BITS-1:0]     paddr,
   input  wire logic [cnbm_pkg::CSR_DATA_BITS-1:0]     pwdata,
   output logic [cnbm_pkg::CSR_DATA_BITS-1:0]          prdata,
   output logic                                        pready
);

   localparam int DW = cnbm_pkg::CSR_DATA_BITS;

   logic [cnbm_pkg::CUT_BITS-1:0] cutoff_ff;
   logic [cnbm_pkg::SPC_BITS-1:0] species_ff;
   logic [cnbm_pkg::MAP_BITS-1:0] map_ff;
   logic [1:0]                    csr_idx;
   logic                          csr_wr;
   cnbm_pkg::cfg_type             cfg;

   logic                          mid_push, mid_full, mid_empty, mid_pop;
   cnbm_pkg::mid_type             mid_wr, mid_rd;
   logic [cnbm_pkg::MID_BITS-1:0] mid_rd_bits;
   logic                          out_push, out_full;
   cnbm_pkg::rsp_type             out_wr;
   logic [cnbm_pkg::RSP_BITS-1:0] out_rd_bits;

   assign pready  = 1'b1;
   assign csr_idx = paddr[cnbm_pkg::CSR_ADDR_BITS-1:3];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff  <= '0;
         species_ff <= cnbm_pkg::SPC_BITS'(1);
         map_ff     <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            cnbm_pkg::CSR_CUTOFF:  cutoff_ff  <= pwdata[cnbm_pkg::CUT_BITS-1:0];
            cnbm_pkg::CSR_SPECIES: species_ff <= pwdata[cnbm_pkg::SPC_BITS-1:0];
            cnbm_pkg::CSR_MAP:     map_ff     <= pwdata[cnbm_pkg::MAP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         cnbm_pkg::CSR_CUTOFF:  prdata = DW'(cutoff_ff);
         cnbm_pkg::CSR_SPECIES: prdata = DW'(species_ff);
         cnbm_pkg::CSR_MAP:     prdata = DW'(map_ff);
         default:               prdata = '0;
      endcase
   end

   assign cfg = '{cutoff_squared: cutoff_ff,
                  species_count:  species_ff,
                  pair_bin_map:   map_ff};

   cnbm_front #(
      .MAX_SPECIES(MAX_SPECIES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg),
      .push_i     (push),
      .req_i      (req_item),
      .full_o     (full),
      .mid_push_o (mid_push),
      .mid_o      (mid_wr),
      .mid_full_i (mid_full)
   );

   cnbm_queue #(
      .WIDTH(cnbm_pkg::MID_BITS),
      .DEPTH(cnbm_pkg::MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (mid_push),
      .data_i  (mid_wr),
      .full_o  (mid_full),
      .pop_i   (mid_pop),
      .data_o  (mid_rd_bits),
      .empty_o (mid_empty)
   );

   assign mid_rd = cnbm_pkg::mid_type'(mid_rd_bits);

   cnbm_back #(
      .MAX_SPECIES(MAX_SPECIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .species_count_i (species_ff),
      .mid_i           (mid_rd),
      .mid_empty_i     (mid_empty),
      .mid_pop_o       (mid_pop),
      .out_full_i      (out_full),
      .out_push_o      (out_push),
      .out_o           (out_wr)
   );

   cnbm_queue #(
      .WIDTH(cnbm_pkg::RSP_BITS),
      .DEPTH(cnbm_pkg::OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push_i  (out_push),
      .data_i  (out_wr),
      .full_o  (out_full),
      .pop_i   (pop),
      .data_o  (out_rd_bits),
      .empty_o (empty)
   );

   assign rsp_item = cnbm_pkg::rsp_type'(out_rd_bits);

endmodule

`default_nettype wire

// ===== rtl/cnbm_checker.sv =====
// ----------------------------------------------------------------------------
// cnbm_checker
// Port-level checks for the neighbor bin counter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "cutoff_neighbor_bin_max_counter_assert.svh"

module cnbm_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              empty,
   input wire logic              pop,
   input wire cnbm_pkg::rsp_type rsp_item,
   input wire logic              psel,
   input wire logic              penable,
   input wire logic              pready
);

   // The configuration port never inserts wait states.
   `CNBM_ASSERT_NOW(a_pready_high, psel && penable, pready, "pready went low")

   // The running maximum always includes the atom being reported.
   `CNBM_ASSERT_NOW(a_max_order, !empty,
                    rsp_item.overall_max_count >= rsp_item.atom_max_count,
                    "running maximum below atom maximum")

   // A waiting beat stays in place until it is popped.
   `CNBM_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_item), "result changed while waiting")

endmodule

bind cutoff_neighbor_bin_max_counter cnbm_checker u_cnbm_checker (.*);

`default_nettype wire

// ===== sim/cutoff_neighbor_bin_max_counter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for cutoff_neighbor_bin_max_counter
// Streams center/neighbor pairs through the block under several register
// settings. A scoreboard class predicts every per-atom report from its own
// copy of the bin counters and the running maximum, and checks each popped
// result in order. Directed pairs cover the coordinate extremes, zero
// distance, the cutoff boundary and species bins. The rest is random atoms
// with random neighbor lists, random gaps on the push side and random stalls
// on the pop side.
// ----------------------------------------------------------------------------

module cutoff_neighbor_bin_max_counter_tb;

   localparam int NUM_BINS     = 4;
   localparam int DRAIN_CYCLES = 16;
   localparam int IDLE_LIMIT   = 2000;
   localparam int CB           = cnbm_pkg::COORD_BITS;
   localparam int CUTB         = cnbm_pkg::CUT_BITS;
   localparam int SPB          = cnbm_pkg::SPC_BITS;
   localparam int MAPB         = cnbm_pkg::MAP_BITS;
   localparam int CNTB         = cnbm_pkg::CNT_BITS;
   localparam int DB           = cnbm_pkg::CSR_DATA_BITS;

   localparam logic [CUTB-1:0] CUTOFF_MAX = {CUTB{1'b1}};
   localparam logic [CB-1:0]   COORD_MIN  = {1'b1, {(CB-1){1'b0}}};
   localparam logic [CB-1:0]   COORD_MAX  = {1'b0, {(CB-1){1'b1}}};

   typedef enum int {
      DRAIN_FREE,
      DRAIN_RANDOM,
      DRAIN_SLOW
   } drain_mode_type;

   // -------------------------------------------------------------------------
   // Scoreboard: predicted bin counters and queue of expected atom reports
   // -------------------------------------------------------------------------
   class bin_count_scoreboard;
      logic [CUTB-1:0]     cutoff;
      logic [SPB-1:0]      species;
      logic [MAPB-1:0]     bin_map;
      logic [CNTB-1:0]     bin_count [NUM_BINS];
      logic [CNTB-1:0]     run_max;
      cnbm_pkg::rsp_type   expected_reports [$];
      int                  errors;
      int                  pairs;
      int                  counted;
      int                  reports;

      function new();
         cutoff  = '0;
         species = SPB'(1);
         bin_map = '0;
         foreach (bin_count[i]) bin_count[i] = '0;
         run_max = '0;
         errors  = 0;
         pairs   = 0;
         counted = 0;
         reports = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [DB-1:0] value);
         case (idx)
            cnbm_pkg::CSR_CUTOFF:  cutoff  = value[CUTB-1:0];
            cnbm_pkg::CSR_SPECIES: species = value[SPB-1:0];
            cnbm_pkg::CSR_MAP:     bin_map = value[MAPB-1:0];
            default: ;
         endcase
      endfunction

      function logic [DB-1:0] reg_value(logic [1:0] idx);
         case (idx)
            cnbm_pkg::CSR_CUTOFF:  return DB'(cutoff);
            cnbm_pkg::CSR_SPECIES: return DB'(species);
            cnbm_pkg::CSR_MAP:     return DB'(bin_map);
            default:               return '0;
         endcase
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void note_pair(cnbm_pkg::req_type p);
         longint                        dx, dy, dz;
         logic [63:0]                   d2;
         int                            n, idx, amax;
         logic [cnbm_pkg::BIN_BITS-1:0] b;
         cnbm_pkg::rsp_type             r;
         n = (species == 0) ? 1 : ((species > NUM_BINS) ? NUM_BINS : int'(species));
         dx = longint'($signed(p.neighbor_x)) - longint'($signed(p.center_x));
         dy = longint'($signed(p.neighbor_y)) - longint'($signed(p.center_y));
         dz = longint'($signed(p.neighbor_z)) - longint'($signed(p.center_z));
         // Differences stay within 25 bits, so the sum of squares cannot overflow.
         d2 = dx * dx + dy * dy + dz * dz;
         pairs++;
         if (d2 != 0 && d2 < 64'(cutoff)) begin
            counted++;
            idx = int'(p.center_species) * n + int'(p.neighbor_species);
            b = '0;
            if (n > 1 && idx < 16) begin
               b = bin_map[2*idx +: 2];
            end
            if (bin_count[b] < cnbm_pkg::COUNT_MAX) begin
               bin_count[b]++;
            end
         end
         if (p.last_neighbor) begin
            amax = 0;
            for (int i = 0; i < n; i++) begin
               if (bin_count[i] > amax) amax = bin_count[i];
            end
            if (amax > run_max) run_max = CNTB'(amax);
            r.atom_max_count    = CNTB'(amax);
            r.overall_max_count = run_max;
            r.final_res         = p.last_atom;
            expected_reports.push_back(r);
            foreach (bin_count[i]) bin_count[i] = '0;
            // A finished list starts the next one from a zero maximum.
            if (p.last_atom) run_max = '0;
         end
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(cnbm_pkg::rsp_type got);
         cnbm_pkg::rsp_type want;
         if (expected_reports.size() == 0) begin
            report_mismatch($sformatf("report beat with none expected (atom %0d overall %0d)",
                                      got.atom_max_count, got.overall_max_count));
            return;
         end
         want = expected_reports.pop_front();
         reports++;
         if (got.atom_max_count !== want.atom_max_count)
            report_mismatch($sformatf("report %0d atom_max_count %0d, expected %0d",
                                      reports, got.atom_max_count, want.atom_max_count));
         if (got.overall_max_count !== want.overall_max_count)
            report_mismatch($sformatf("report %0d overall_max_count %0d, expected %0d",
                                      reports, got.overall_max_count, want.overall_max_count));
         if (got.final_res !== want.final_res)
            report_mismatch($sformatf("report %0d final_res %0b, expected %0b",
                                      reports, got.final_res, want.final_res));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Signals and block instance
   // -------------------------------------------------------------------------
   logic                               clock    = 1'b0;
   logic                               reset    = 1'b1;
   logic                               push     = 1'b0;
   cnbm_pkg::req_type                  req_item = '0;
   logic                               full;
   logic                               empty;
   logic                               pop      = 1'b0;
   cnbm_pkg::rsp_type                  rsp_item;
   logic                               psel     = 1'b0;
   logic                               penable  = 1'b0;
   logic                               pwrite   = 1'b0;
   logic [cnbm_pkg::CSR_ADDR_BITS-1:0] paddr    = '0;
   logic [DB-1:0]                      pwdata   = '0;
   logic [DB-1:0]                      prdata;
   logic                               pready;

   bin_count_scoreboard bin_sb;
   int                  burst_left = 0;
   int                  idle_cycles = 0;
   int                  settings_run = 0;

   cutoff_neighbor_bin_max_counter i_dut (.*);

   always #1 clock = ~clock;

   // Ends the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Result side: pops on a stall pattern that switches between modes.
   initial begin
      drain_mode_type mode;
      int             mode_left;
      int             step;
      logic           nxt;
      mode      = DRAIN_FREE;
      mode_left = 0;
      step      = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = drain_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 200);
            step      = 0;
         end
         mode_left--;
         step++;
         case (mode)
            DRAIN_FREE:   nxt = 1'b1;
            DRAIN_RANDOM: nxt = 1'($urandom_range(0, 1));
            default:      nxt = (step % 14) >= 11;
         endcase
         pop <= reset ? 1'b0 : nxt;
         @(posedge clock);
         if (!reset && pop && !empty) bin_sb.check_result(rsp_item);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   task automatic send_pair(input cnbm_pkg::req_type p);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            @(negedge clock);
            push <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      push     <= 1'b1;
      req_item <= p;
      do @(posedge clock); while (full);
      bin_sb.note_pair(p);
   endtask

   // Waits until every report has been popped and the pipeline has emptied.
   task automatic wait_block_idle();
      @(negedge clock);
      push <= 1'b0;
      while (bin_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_reg(input logic [1:0] idx);
      logic [DB-1:0] got;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 3'b000};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== bin_sb.reg_value(idx))
         bin_sb.report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                          idx, got, bin_sb.reg_value(idx)));
   endtask

   task automatic program_reg(input logic [1:0] idx, input logic [DB-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      bin_sb.set_reg(idx, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_reg(idx);
   endtask

   task automatic program_all(input logic [CUTB-1:0] cutoff,
                              input logic [SPB-1:0]  species,
                              input logic [MAPB-1:0] bin_map);
      program_reg(cnbm_pkg::CSR_CUTOFF, DB'(cutoff));
      program_reg(cnbm_pkg::CSR_SPECIES, DB'(species));
      program_reg(cnbm_pkg::CSR_MAP, DB'(bin_map));
      settings_run++;
   endtask

   // -------------------------------------------------------------------------
   // Pair generation
   // -------------------------------------------------------------------------
   function automatic cnbm_pkg::req_type make_pair(logic [CB-1:0] cx, logic [CB-1:0] cy,
                                                   logic [CB-1:0] cz, logic [CB-1:0] nx,
                                                   logic [CB-1:0] ny, logic [CB-1:0] nz,
                                                   logic [1:0] cs, logic [1:0] ns,
                                                   logic ln, logic la);
      cnbm_pkg::req_type p;
      p.center_x         = cx;
      p.center_y         = cy;
      p.center_z         = cz;
      p.neighbor_x       = nx;
      p.neighbor_y       = ny;
      p.neighbor_z       = nz;
      p.center_species   = cs;
      p.neighbor_species = ns;
      p.last_neighbor    = ln;
      p.last_atom        = la;
      return p;
   endfunction

   function automatic logic [CB-1:0] center_coord();
      case ($urandom_range(0, 3))
         0:       return CB'($urandom);
         1:       return CB'(int'($urandom_range(0, 4095)) - 2048);
         2:       return COORD_MIN + CB'($urandom_range(0, 255));
         default: return COORD_MAX - CB'($urandom_range(0, 255));
      endcase
   endfunction

   // Offsets may wrap past the coordinate range; the pair is then simply far.
   function automatic logic [CB-1:0] offset_coord(logic [CB-1:0] c, int unsigned radius);
      int off;
      off = int'($urandom_range(0, 2 * radius)) - int'(radius);
      return c + CB'(off);
   endfunction

   // Atoms with neighbor lists around the cutoff radius, plus stray flags.
   task automatic run_random_atoms(input int unsigned radius, input int target);
      int            sent;
      int            nn;
      logic [1:0]    cs;
      logic [CB-1:0] cx, cy, cz, nx, ny, nz;
      logic          ln, la;
      sent = 0;
      while (sent < target) begin
         cs = 2'($urandom_range(0, 3));
         cx = center_coord();
         cy = center_coord();
         cz = center_coord();
         nn = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80) : $urandom_range(1, 24);
         for (int k = 0; k < nn; k++) begin
            case ($urandom_range(0, 15))
               0: begin
                  nx = cx;
                  ny = cy;
                  nz = cz;
               end
               1: begin
                  nx = CB'($urandom);
                  ny = CB'($urandom);
                  nz = CB'($urandom);
               end
               default: begin
                  nx = offset_coord(cx, radius);
                  ny = offset_coord(cy, radius);
                  nz = offset_coord(cz, radius);
               end
            endcase
            ln = (k == nn - 1);
            // Occasionally a pair ends its atom early, which breaks the list.
            if (!ln && $urandom_range(0, 39) == 0) ln = 1'b1;
            la = ln ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 11) == 0);
            send_pair(make_pair(cx, cy, cz, nx, ny, nz, cs, 2'($urandom_range(0, 3)), ln, la));
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int              species_list [8];
      int unsigned     radius;
      logic [CUTB-1:0] cutoff;
      logic [MAPB-1:0] bin_map;
      species_list = '{3, 0, 4, 7, 2, 1, 5, 4};
      bin_sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers come out of reset at their documented values.
      check_reg(cnbm_pkg::CSR_CUTOFF);
      check_reg(cnbm_pkg::CSR_SPECIES);
      check_reg(cnbm_pkg::CSR_MAP);

      // Widest cutoff: opposite corners count, coincident atoms do not.
      program_all(CUTOFF_MAX, SPB'(1), '0);
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX,
                          2'd0, 2'd0, 1'b0, 1'b0));
      send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                          2'd3, 2'd3, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, '0, '0, '0, 2'd1, 2'd2, 1'b0, 1'b0));
      send_pair(make_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                          2'd2, 2'd1, 1'b1, 1'b0));
      send_pair(make_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                          2'd0, 2'd0, 1'b1, 1'b1));
      send_pair(make_pair('1, '0, '0, '0, '0, '0, 2'd0, 2'd0, 1'b1, 1'b0));
      wait_block_idle();

      // A squared distance equal to the cutoff is outside it.
      program_all(CUTB'(3), SPB'(1), '0);
      send_pair(make_pair('0, '0, '0, 24'd1, '0, '0, 2'd0, 2'd0, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, 24'd1, 24'd1, '0, 2'd0, 2'd0, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, 24'd1, 24'd1, 24'd1, 2'd0, 2'd0, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, '1, '0, '0, 2'd0, 2'd0, 1'b1, 1'b0));
      wait_block_idle();

      // Four species: each map entry sends the pair to the bin of its neighbor.
      program_all(CUTB'(64'd1 << 30), SPB'(4), 32'hE4E4_E4E4);
      send_pair(make_pair('0, '0, '0, 24'd1, '0, '0, 2'd0, 2'd0, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, 24'd1, '0, '0, 2'd1, 2'd1, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, 24'd1, '0, '0, 2'd2, 2'd1, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, 24'd1, '0, '0, 2'd3, 2'd3, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, 24'd1, '0, '0, 2'd3, 2'd2, 1'b0, 1'b1));
      send_pair(make_pair('0, '0, '0, '0, '0, '0, 2'd0, 2'd1, 1'b1, 1'b0));
      send_pair(make_pair('0, '0, '0, '0, 24'd5, '0, 2'd1, 2'd3, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, '0, '0, 24'd7, 2'd2, 2'd3, 1'b0, 1'b0));
      send_pair(make_pair('0, '0, '0, '1, '1, '1, 2'd3, 2'd3, 1'b1, 1'b1));
      wait_block_idle();

      for (int ph = 0; ph < 8; ph++) begin
         radius = $urandom_range(16, 1 << 22);
         cutoff = CUTB'(64'(radius) * 64'(radius));
         if (ph == 1) begin
            cutoff = CUTOFF_MAX;
            radius = 1 << 23;
         end else if (ph == 5) begin
            cutoff = '0;
         end
         if (ph % 3 == 0) bin_map = '1;
         else if (ph == 4) bin_map = '0;
         else bin_map = MAPB'($urandom);
         program_all(cutoff, SPB'(species_list[ph]), bin_map);
         run_random_atoms(radius, 180);
         wait_block_idle();
      end

      $display("Ran %0d pairs over %0d register settings: %0d inside the cutoff,",
               bin_sb.pairs, settings_run, bin_sb.counted);
      $display("and checked %0d atom reports.", bin_sb.reports);
      if (bin_sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== cutoff_neighbor_bin_max_counter.f =====
+incdir+rtl
rtl/cnbm_pkg.sv
rtl/cnbm_queue.sv
rtl/cnbm_front.sv
rtl/cnbm_back.sv
rtl/cutoff_neighbor_bin_max_counter.sv
rtl/cnbm_checker.sv
sim/cutoff_neighbor_bin_max_counter_tb.sv
